>>> hw/rtl/image_convolution_clamped_unit_macros.svh
// Assertion macros shared by the checker of the convolution unit.
`ifndef IMAGE_CONVOLUTION_CLAMPED_UNIT_MACROS_SVH
`define IMAGE_CONVOLUTION_CLAMPED_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ICC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ICC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/icc_pkg.sv
// Package of the convolution unit: sizes, codes and shared types.
package icc_pkg;

   // store sizes
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_KERNEL = 7;
   localparam int CHANNELS   = 3;
   localparam int SUM_CHANS  = 3;
   localparam int MAX_RADIUS = (MAX_KERNEL - 1) / 2;

   // word fields
   localparam int TYPE_W  = 2;
   localparam int COORD_W = 8;
   localparam int CHAN_W  = 2;
   localparam int DATA_W  = 16;

   // derived widths
   localparam int X_W          = $clog2(MAX_WIDTH);
   localparam int Y_W          = $clog2(MAX_HEIGHT);
   localparam int KI_W         = $clog2(MAX_KERNEL + 1);
   localparam int KERNEL_DEPTH = MAX_KERNEL * MAX_KERNEL;
   localparam int KADDR_W      = $clog2(KERNEL_DEPTH);
   localparam int IMG_DEPTH    = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
   localparam int IMG_AW       = $clog2(IMG_DEPTH);
   localparam int PROD_W       = 2 * DATA_W;
   localparam int ACC_W        = PROD_W + $clog2(KERNEL_DEPTH * SUM_CHANS) + 1;
   localparam int FRAC_SHIFT   = 14;
   localparam int Q_W          = ACC_W - FRAC_SHIFT;
   localparam int OUT_MAX      = 2 ** (DATA_W - 1) - 1;
   localparam int OUT_MIN      = -(2 ** (DATA_W - 1));

   // register file
   localparam int NUM_REGS  = 5;
   localparam int PADDR_W   = $clog2(NUM_REGS * 4);
   localparam int PDATA_W   = 32;
   localparam int REG_IDX_W = PADDR_W - 2;
   localparam int SIZE_W    = 9;
   localparam int COUNT_W   = 2;
   localparam int RAD_W     = 2;

   localparam logic [SIZE_W-1:0]  WIDTH_RESET    = SIZE_W'(256);
   localparam logic [SIZE_W-1:0]  HEIGHT_RESET   = SIZE_W'(256);
   localparam logic [COUNT_W-1:0] COUNT_RESET    = COUNT_W'(3);
   localparam logic [RAD_W-1:0]   RADIUS_RESET   = RAD_W'(1);
   localparam logic               PRESERVE_RESET = 1'b1;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_IMAGE_WIDTH       = 3'd0,
      REG_IMAGE_HEIGHT      = 3'd1,
      REG_CHANNEL_COUNT     = 3'd2,
      REG_KERNEL_RADIUS     = 3'd3,
      REG_PRESERVE_CHANNELS = 3'd4
   } reg_index_type;

   typedef enum logic [TYPE_W-1:0] {
      REQ_LOAD_PIXEL = 2'd0,
      REQ_LOAD_COEF  = 2'd1,
      REQ_COMPUTE    = 2'd2
   } req_kind_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  image_width;
      logic [SIZE_W-1:0]  image_height;
      logic [COUNT_W-1:0] channel_count;
      logic [RAD_W-1:0]   kernel_radius;
      logic               preserve_channels;
   } cfg_type;

   typedef struct packed {
      logic load_pixel;
      logic load_coef;
      logic start;
      logic step;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_tap;
      logic pipe_busy;
      logic out_free;
   } dp_status_type;

endpackage

>>> hw/rtl/icc_channels.sv
// Handshake channels of the convolution unit: request and response.
interface icc_req_if;
   import icc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [TYPE_W-1:0]        req_type;
   logic [COORD_W-1:0]       col;
   logic [COORD_W-1:0]       row;
   logic [CHAN_W-1:0]        chan;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, req_type, col, row, chan, value, input ready);
   modport sink (input valid, req_type, col, row, chan, value, output ready);
endinterface

interface icc_rsp_if;
   import icc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result;
   logic                     saturated;

   modport source (output valid, result, saturated, input ready);
   modport sink (input valid, result, saturated, output ready);
endinterface

>>> hw/rtl/icc_csr.sv
// Configuration registers of the convolution unit behind the APB port.
module icc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [icc_pkg::PADDR_W-1:0]   paddr,
   input  logic [icc_pkg::PDATA_W-1:0]   pwdata,
   output logic [icc_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready,
   output icc_pkg::cfg_type              cfg
);
   import icc_pkg::*;

   cfg_type                cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   wr_en;

   assign reg_idx = paddr[PADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_IMAGE_WIDTH:       cfg_in.image_width       = pwdata[SIZE_W-1:0];
            REG_IMAGE_HEIGHT:      cfg_in.image_height      = pwdata[SIZE_W-1:0];
            REG_CHANNEL_COUNT:     cfg_in.channel_count     = pwdata[COUNT_W-1:0];
            REG_KERNEL_RADIUS:     cfg_in.kernel_radius     = pwdata[RAD_W-1:0];
            REG_PRESERVE_CHANNELS: cfg_in.preserve_channels = pwdata[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_IMAGE_WIDTH:       prdata = PDATA_W'(cfg_ff.image_width);
         REG_IMAGE_HEIGHT:      prdata = PDATA_W'(cfg_ff.image_height);
         REG_CHANNEL_COUNT:     prdata = PDATA_W'(cfg_ff.channel_count);
         REG_KERNEL_RADIUS:     prdata = PDATA_W'(cfg_ff.kernel_radius);
         REG_PRESERVE_CHANNELS: prdata = PDATA_W'(cfg_ff.preserve_channels);
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width       <= WIDTH_RESET;
         cfg_ff.image_height      <= HEIGHT_RESET;
         cfg_ff.channel_count     <= COUNT_RESET;
         cfg_ff.kernel_radius     <= RADIUS_RESET;
         cfg_ff.preserve_channels <= PRESERVE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/icc_ctrl.sv
// Controller of the convolution unit: accepts words and sequences the taps.
module icc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [icc_pkg::TYPE_W-1:0]  req_type,
   output logic                        req_ready,
   output icc_pkg::ctrl_cmd_type       cmd,
   input  icc_pkg::dp_status_type      status
);
   import icc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_LOAD_PIXEL: cmd.load_pixel = 1'b1;
                  REQ_LOAD_COEF:  cmd.load_coef  = 1'b1;
                  REQ_COMPUTE: begin
                     cmd.start = 1'b1;
                     state_in  = ST_RUN;
                  end
                  default: state_in = ST_IDLE; // unknown kind: dropped
               endcase
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (status.last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the MAC pipe to empty and the result register to free
            if (!status.pipe_busy && status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/icc_datapath.sv
// Datapath of the convolution unit: stores, tap address generation, MAC and output stage.
module icc_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  icc_pkg::ctrl_cmd_type              cmd,
   output icc_pkg::dp_status_type             status,
   input  icc_pkg::cfg_type                   cfg,
   input  logic [icc_pkg::COORD_W-1:0]        col,
   input  logic [icc_pkg::COORD_W-1:0]        row,
   input  logic [icc_pkg::CHAN_W-1:0]         chan,
   input  logic signed [icc_pkg::DATA_W-1:0]  value,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic signed [icc_pkg::DATA_W-1:0]  result,
   output logic                               saturated
);
   import icc_pkg::*;

   localparam int NX_W = X_W + 2;
   localparam int NY_W = Y_W + 2;

   // stores
   logic signed [DATA_W-1:0] img_mem  [IMG_DEPTH];
   logic signed [DATA_W-1:0] coef_mem [KERNEL_DEPTH];

   // per-item context
   logic [X_W-1:0]    xmax_ff, xmax_in, x_ff, x_in;
   logic [Y_W-1:0]    ymax_ff, ymax_in, y_ff, y_in;
   logic [CHAN_W-1:0] cmax_ff, cmax_in, chan_ff, chan_in;
   logic              preserve_ff, preserve_in;
   logic [RAD_W-1:0]  r_ff, r_in;
   logic [KI_W-1:0]   span_ff, span_in;

   // tap counters
   logic [KI_W-1:0]   ti_ff, ti_in, tj_ff, tj_in;
   logic [CHAN_W-1:0] tc_ff, tc_in, last_c;

   // stage 1: clamped neighbour
   logic signed [NX_W-1:0] nx;
   logic signed [NY_W-1:0] ny;
   logic [CHAN_W-1:0]      c_src;
   logic [X_W-1:0]         sx_ff, sx_in;
   logic [Y_W-1:0]         sy_ff, sy_in;
   logic [CHAN_W-1:0]      sc_ff, sc_in;
   logic [KADDR_W-1:0]     skaddr_ff, skaddr_in;
   logic                   v1_ff;

   // stage 2: store reads
   logic [IMG_AW-1:0]        img_raddr, img_waddr;
   logic [KADDR_W-1:0]       coef_waddr;
   logic                     img_we, coef_we;
   logic signed [DATA_W-1:0] img_rd_ff, coef_rd_ff;
   logic                     v2_ff;

   // stage 3/4: multiply, accumulate
   logic signed [PROD_W-1:0] prod_ff;
   logic                     v3_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   // output register
   logic signed [Q_W-1:0]    q;
   logic                     sat_hi, sat_lo;
   logic signed [DATA_W-1:0] result_ff, result_in;
   logic                     sat_ff, sat_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // ---------------- context capture at start ----------------
   always_comb begin
      xmax_in     = xmax_ff;
      ymax_in     = ymax_ff;
      cmax_in     = cmax_ff;
      r_in        = r_ff;
      span_in     = span_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      chan_in     = chan_ff;
      preserve_in = preserve_ff;
      if (cmd.start) begin
         if (cfg.image_width == '0) begin
            xmax_in = '0;
         end else if (int'(cfg.image_width) > MAX_WIDTH) begin
            xmax_in = X_W'(MAX_WIDTH - 1);
         end else begin
            xmax_in = X_W'(cfg.image_width - SIZE_W'(1));
         end
         if (cfg.image_height == '0) begin
            ymax_in = '0;
         end else if (int'(cfg.image_height) > MAX_HEIGHT) begin
            ymax_in = Y_W'(MAX_HEIGHT - 1);
         end else begin
            ymax_in = Y_W'(cfg.image_height - SIZE_W'(1));
         end
         if (cfg.channel_count == '0) begin
            cmax_in = '0;
         end else if (int'(cfg.channel_count) > CHANNELS) begin
            cmax_in = CHAN_W'(CHANNELS - 1);
         end else begin
            cmax_in = CHAN_W'(cfg.channel_count - COUNT_W'(1));
         end
         r_in        = (int'(cfg.kernel_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                              : cfg.kernel_radius;
         span_in     = KI_W'(2 * int'(r_in));
         x_in        = (int'(col) > int'(xmax_in)) ? xmax_in : X_W'(col);
         y_in        = (int'(row) > int'(ymax_in)) ? ymax_in : Y_W'(row);
         chan_in     = chan;
         preserve_in = cfg.preserve_channels;
      end
   end

   // ---------------- tap counters ----------------
   assign last_c = preserve_ff ? '0 : CHAN_W'(SUM_CHANS - 1);

   always_comb begin
      ti_in = ti_ff;
      tj_in = tj_ff;
      tc_in = tc_ff;
      if (cmd.start) begin
         ti_in = '0;
         tj_in = '0;
         tc_in = '0;
      end else if (cmd.step) begin
         if (tc_ff == last_c) begin
            tc_in = '0;
            if (tj_ff == span_ff) begin
               tj_in = '0;
               ti_in = ti_ff + KI_W'(1);
            end else begin
               tj_in = tj_ff + KI_W'(1);
            end
         end else begin
            tc_in = tc_ff + CHAN_W'(1);
         end
      end
   end

   assign status.last_tap  = (ti_ff == span_ff) && (tj_ff == span_ff) && (tc_ff == last_c);
   assign status.pipe_busy = v1_ff || v2_ff || v3_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // ---------------- stage 1: neighbour clamp ----------------
   always_comb begin
      nx = $signed(NX_W'(x_ff)) + $signed(NX_W'(ti_ff)) - $signed(NX_W'(r_ff));
      ny = $signed(NY_W'(y_ff)) + $signed(NY_W'(tj_ff)) - $signed(NY_W'(r_ff));
      if (nx < 0) begin
         sx_in = '0;
      end else if (nx > $signed(NX_W'(xmax_ff))) begin
         sx_in = xmax_ff;
      end else begin
         sx_in = nx[X_W-1:0];
      end
      if (ny < 0) begin
         sy_in = '0;
      end else if (ny > $signed(NY_W'(ymax_ff))) begin
         sy_in = ymax_ff;
      end else begin
         sy_in = ny[Y_W-1:0];
      end
      c_src     = preserve_ff ? chan_ff : tc_ff;
      sc_in     = (c_src > cmax_ff) ? cmax_ff : c_src;
      skaddr_in = KADDR_W'(int'(tj_ff) * MAX_KERNEL + int'(ti_ff));
   end

   // ---------------- stores ----------------
   assign img_waddr  = IMG_AW'((int'(row) * MAX_WIDTH + int'(col)) * CHANNELS + int'(chan));
   assign img_we     = cmd.load_pixel && (int'(col) < MAX_WIDTH) &&
                       (int'(row) < MAX_HEIGHT) && (int'(chan) < CHANNELS);
   assign coef_waddr = KADDR_W'(int'(row) * MAX_KERNEL + int'(col));
   assign coef_we    = cmd.load_coef && (int'(col) < MAX_KERNEL) && (int'(row) < MAX_KERNEL);
   assign img_raddr  = IMG_AW'((int'(sy_ff) * MAX_WIDTH + int'(sx_ff)) * CHANNELS +
                               int'(sc_ff));

   always_ff @(posedge clock) begin
      if (img_we) begin
         img_mem[img_waddr] <= value;
      end
      if (v1_ff) begin
         img_rd_ff <= img_mem[img_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= value;
      end
      if (v1_ff) begin
         coef_rd_ff <= coef_mem[skaddr_ff];
      end
   end

   // ---------------- accumulate and output ----------------
   always_comb begin
      acc_in = acc_ff;
      if (cmd.start) begin
         acc_in = '0;
      end else if (v3_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_comb begin
      q         = Q_W'(acc_ff >>> FRAC_SHIFT); // floor division by 2^14
      sat_hi    = q > OUT_MAX;
      sat_lo    = q < OUT_MIN;
      result_in = result_ff;
      sat_in    = sat_ff;
      if (cmd.finish) begin
         result_in = sat_hi ? DATA_W'(OUT_MAX) : (sat_lo ? DATA_W'(OUT_MIN) : q[DATA_W-1:0]);
         sat_in    = sat_hi || sat_lo;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;
   assign saturated = sat_ff;

   // payload registers
   always_ff @(posedge clock) begin
      xmax_ff     <= xmax_in;
      ymax_ff     <= ymax_in;
      cmax_ff     <= cmax_in;
      r_ff        <= r_in;
      span_ff     <= span_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      chan_ff     <= chan_in;
      preserve_ff <= preserve_in;
      ti_ff       <= ti_in;
      tj_ff       <= tj_in;
      tc_ff       <= tc_in;
      if (cmd.step) begin
         sx_ff     <= sx_in;
         sy_ff     <= sy_in;
         sc_ff     <= sc_in;
         skaddr_ff <= skaddr_in;
      end
      if (v2_ff) begin
         prod_ff <= img_rd_ff * coef_rd_ff;
      end
      acc_ff    <= acc_in;
      result_ff <= result_in;
      sat_ff    <= sat_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= cmd.step;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/image_convolution_clamped_unit.sv
// Load words may follow back to back.
// A compute word visits T taps, T = (2r+1)^2 in preserve mode, 3*(2r+1)^2 otherwise (max 147).
// The result is registered once the MAC pipe drains and the result register is free;
// no word is taken before then. The single shared multiply-accumulate takes one tap per cycle.
// Reset (synchronous, active high) clears control and restores register defaults;
// the pixel and coefficient stores keep their contents and must be written before use.
module image_convolution_clamped_unit (
   input  logic                          clock,
   input  logic                          reset,
   icc_req_if.sink                       req_ch,
   icc_rsp_if.source                     rsp_ch,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [icc_pkg::PADDR_W-1:0]   paddr,
   input  logic [icc_pkg::PDATA_W-1:0]   pwdata,
   output logic [icc_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);
   import icc_pkg::*;

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // register file: width, height, channel count, radius, channel mode
   icc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: idle takes words, run steps the taps, drain waits for the
   // MAC pipe (address, read, multiply, add) and a free result register
   icc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // stores plus MAC; the result register parts the response side, so loads
   // keep flowing while a result waits to be taken
   icc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .cfg       (cfg),
      .col       (req_ch.col),
      .row       (req_ch.row),
      .chan      (req_ch.chan),
      .value     (req_ch.value),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .result    (rsp_ch.result),
      .saturated (rsp_ch.saturated)
   );

endmodule

>>> hw/rtl/icc_checker.sv
// Port-level checker of the convolution unit and its bind.
`include "image_convolution_clamped_unit_macros.svh"

module icc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [icc_pkg::TYPE_W-1:0]         req_type,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [icc_pkg::DATA_W-1:0]  result,
   input logic                               saturated
);
   import icc_pkg::*;

   // a waiting result word holds
   `ICC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(result) && $stable(saturated), "result word changed while stalled")

   // a compute word busies the unit for its taps
   `ICC_ASSERT_NEXT(a_compute_busy, req_valid && req_ready && req_type == REQ_COMPUTE, !req_ready, "ready stayed high after a compute word")

   // load words and unknown kinds leave the unit ready
   `ICC_ASSERT_NEXT(a_load_ready, req_valid && req_ready && req_type != REQ_COMPUTE, req_ready, "ready dropped after a load word")

   // a saturated result sits at one of the rails
   `ICC_ASSERT_SAME(a_sat_rail, rsp_valid && saturated, result == 16'sh7FFF || result == 16'sh8000, "saturated flag without a rail value")

endmodule

bind image_convolution_clamped_unit icc_checker u_icc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_type  (req_ch.req_type),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .result    (rsp_ch.result),
   .saturated (rsp_ch.saturated)
);

>>> tb/image_convolution_clamped_unit_tb.sv
// Self-checking testbench for the clamp-to-edge image convolution unit.
`timescale 1ns / 100ps

module image_convolution_clamped_unit_tb;
   import icc_pkg::*;

   // --------------------------------------------------------------------------
   // Constants
   // --------------------------------------------------------------------------
   // type code the block must drop without a result
   localparam logic [TYPE_W-1:0] REQ_UNUSED  = 2'd3;
   // channel index one past the store; a pixel load with it is dropped
   localparam logic [CHAN_W-1:0] CHAN_BEYOND = 2'd3;

   localparam int ITEM_TARGET     = 1600;  // words in the whole run
   localparam int PHASE_WORDS     = 40;    // operations per random setting
   localparam int SETTLE_CYCLES   = 160;   // covers 147 taps plus the pipe
   localparam int HOLD_OFF_CYCLES = 400;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no traffic at all
   localparam int MAX_REPORTS     = 10;

   typedef struct {
      logic signed [DATA_W-1:0] result;
      logic                     saturated;
   } pixel_result_type;

   // --------------------------------------------------------------------------
   // Clock, reset and block
   // --------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   icc_req_if req_ch ();
   icc_rsp_if rsp_ch ();

   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [PADDR_W-1:0]  paddr;
   logic [PDATA_W-1:0]  pwdata;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   image_convolution_clamped_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // --------------------------------------------------------------------------
   // Shadow of the block: stores, registers and pending filtered pixels
   // --------------------------------------------------------------------------
   logic signed [DATA_W-1:0] pixel_shadow [IMG_DEPTH];
   bit                       pixel_known  [IMG_DEPTH];  // never read an unwritten pixel
   logic signed [DATA_W-1:0] coef_shadow  [KERNEL_DEPTH];
   cfg_type                  cfg_shadow;

   pixel_result_type expected_pixels [$];

   // sender idling, and the hold-off handed to the receiver process
   bit sender_idles;
   int burst_left;
   int hold_off_request;

   // bookkeeping
   int mismatches;
   int words_counted;
   int pixel_words, coef_words, compute_words, dropped_words;
   int results_checked, saturated_seen, settings_used;

   // --------------------------------------------------------------------------
   // Predictor
   // --------------------------------------------------------------------------
   function automatic int clamp_int(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // registers as the block uses them: out-of-range values saturate
   function automatic void get_geometry(output int w, output int h, output int nc,
                                        output int r);
      w  = clamp_int(int'(cfg_shadow.image_width), 1, MAX_WIDTH);
      h  = clamp_int(int'(cfg_shadow.image_height), 1, MAX_HEIGHT);
      nc = clamp_int(int'(cfg_shadow.channel_count), 1, CHANNELS);
      r  = clamp_int(int'(cfg_shadow.kernel_radius), 0, MAX_RADIUS);
   endfunction

   // store slot of a neighbour, clamped to the image and channels in use
   function automatic int pixel_slot(int x, int y, int c);
      int w, h, nc, r;
      get_geometry(w, h, nc, r);
      x = clamp_int(x, 0, w - 1);
      y = clamp_int(y, 0, h - 1);
      c = clamp_int(c, 0, nc - 1);
      return (y * MAX_WIDTH + x) * CHANNELS + c;
   endfunction

   // Unflipped correlation: pixel(x+i, y+j) meets coef(r+i, r+j). Q3.12 times
   // Q1.14 accumulates exactly; floor shift by 14, then saturate to 16 bits.
   function automatic pixel_result_type convolve_clamped(logic [COORD_W-1:0] col,
                                                          logic [COORD_W-1:0] row,
                                                          logic [CHAN_W-1:0]  chan);
      pixel_result_type res;
      int               w, h, nc, r, x, y;
      longint           acc, q, coef;
      get_geometry(w, h, nc, r);
      x   = clamp_int(int'(col), 0, w - 1);
      y   = clamp_int(int'(row), 0, h - 1);
      acc = 0;
      for (int j = -r; j <= r; j++) begin
         for (int i = -r; i <= r; i++) begin
            coef = coef_shadow[(j + r) * MAX_KERNEL + (i + r)];
            if (cfg_shadow.preserve_channels) begin
               acc += longint'(pixel_shadow[pixel_slot(x + i, y + j, int'(chan))]) * coef;
            end else begin
               // channel field ignored; 0..2 each clamped to the count in use
               for (int c = 0; c < SUM_CHANS; c++) begin
                  acc += longint'(pixel_shadow[pixel_slot(x + i, y + j, c)]) * coef;
               end
            end
         end
      end
      q = acc >>> FRAC_SHIFT;
      res.saturated = (q > OUT_MAX) || (q < OUT_MIN);
      if (q > OUT_MAX) q = OUT_MAX;
      if (q < OUT_MIN) q = OUT_MIN;
      res.result = q[DATA_W-1:0];
      return res;
   endfunction

   // --------------------------------------------------------------------------
   // Random values
   // --------------------------------------------------------------------------
   // mostly within unity so sums land in range; one in five uses every bit
   function automatic logic signed [DATA_W-1:0] random_pixel();
      if ($urandom_range(0, 4) == 0) return DATA_W'($urandom);
      return DATA_W'($urandom_range(0, 8191) - 4096);
   endfunction

   function automatic logic signed [DATA_W-1:0] random_coef();
      if ($urandom_range(0, 4) == 0) return DATA_W'($urandom);
      return DATA_W'($urandom_range(0, 4095) - 2048);
   endfunction

   // small images: half inside, half anywhere; full size: mostly corners
   // and one window, so the pixels already loaded get reused
   function automatic logic [COORD_W-1:0] pick_coord(int extent);
      if (extent <= 16) begin
         if ($urandom_range(0, 1) == 0) return COORD_W'($urandom_range(0, extent - 1));
         return COORD_W'($urandom_range(0, 255));
      end
      case ($urandom_range(0, 15))
         0:                       return COORD_W'($urandom_range(0, 255));
         1, 2, 3, 4, 5, 6:        return COORD_W'($urandom_range(0, 3));
         7, 8, 9, 10, 11, 12:     return COORD_W'($urandom_range(extent - 4, extent - 1));
         default:                 return COORD_W'($urandom_range(124, 131));
      endcase
   endfunction

   // register value for a size: legal, zero, or past the store
   function automatic int random_extent();
      case ($urandom_range(0, 7))
         0:       return 1;
         1:       return 0;
         2:       return $urandom_range(257, 511);
         3, 4:    return 256;
         default: return $urandom_range(2, 12);
      endcase
   endfunction

   // --------------------------------------------------------------------------
   // Request side: one word per call, shadow updated when the word is taken
   // --------------------------------------------------------------------------
   task automatic send_word(logic [TYPE_W-1:0] kind, logic [COORD_W-1:0] col,
                            logic [COORD_W-1:0] row, logic [CHAN_W-1:0] chan,
                            logic signed [DATA_W-1:0] value);
      int gap;
      int slot;
      gap = 0;
      if (sender_idles) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.col      <= col;
      req_ch.row      <= row;
      req_ch.chan     <= chan;
      req_ch.value    <= value;
      do @(posedge clock); while (!req_ch.ready);
      words_counted++;

      case (kind)
         REQ_LOAD_PIXEL: begin
            if (chan < CHANNELS) begin
               slot               = (int'(row) * MAX_WIDTH + int'(col)) * CHANNELS + int'(chan);
               pixel_shadow[slot] = value;
               pixel_known[slot]  = 1'b1;
               pixel_words++;
            end else begin
               dropped_words++;
            end
         end
         REQ_LOAD_COEF: begin
            if (col < MAX_KERNEL && row < MAX_KERNEL) begin
               coef_shadow[int'(row) * MAX_KERNEL + int'(col)] = value;
               coef_words++;
            end else begin
               dropped_words++;
            end
         end
         REQ_COMPUTE: begin
            expected_pixels.push_back(convolve_clamped(col, row, chan));
            compute_words++;
         end
         default: dropped_words++;
      endcase
   endtask

   // Loads whatever the neighbourhood still lacks, then asks for the pixel.
   task automatic compute_at(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                             logic [CHAN_W-1:0] chan);
      int w, h, nc, r, x, y, c_first, c_last, slot;
      get_geometry(w, h, nc, r);
      x       = clamp_int(int'(col), 0, w - 1);
      y       = clamp_int(int'(row), 0, h - 1);
      c_first = cfg_shadow.preserve_channels ? int'(chan) : 0;
      c_last  = cfg_shadow.preserve_channels ? int'(chan) : SUM_CHANS - 1;
      for (int j = -r; j <= r; j++) begin
         for (int i = -r; i <= r; i++) begin
            for (int c = c_first; c <= c_last; c++) begin
               slot = pixel_slot(x + i, y + j, c);
               if (!pixel_known[slot]) begin
                  send_word(REQ_LOAD_PIXEL, COORD_W'((slot / CHANNELS) % MAX_WIDTH),
                            COORD_W'(slot / (CHANNELS * MAX_WIDTH)),
                            CHAN_W'(slot % CHANNELS), random_pixel());
               end
            end
         end
      end
      send_word(REQ_COMPUTE, col, row, chan, DATA_W'($urandom));
   endtask

   // one of the three ways a word gets dropped
   task automatic send_noise();
      case ($urandom_range(0, 2))
         0: send_word(REQ_UNUSED, COORD_W'($urandom), COORD_W'($urandom),
                      CHAN_W'($urandom), DATA_W'($urandom));
         1: send_word(REQ_LOAD_PIXEL, COORD_W'($urandom), COORD_W'($urandom),
                      CHAN_BEYOND, DATA_W'($urandom));
         default: begin
            if ($urandom_range(0, 1) == 0)
               send_word(REQ_LOAD_COEF, COORD_W'($urandom_range(MAX_KERNEL, 255)),
                         COORD_W'($urandom), CHAN_W'($urandom), DATA_W'($urandom));
            else
               send_word(REQ_LOAD_COEF, COORD_W'($urandom),
                         COORD_W'($urandom_range(MAX_KERNEL, 255)),
                         CHAN_W'($urandom), DATA_W'($urandom));
         end
      endcase
   endtask

   // Drop valid, wait for every filtered pixel, then let a full compute's worth
   // of cycles pass: a trailing load may still be in flight.
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // --------------------------------------------------------------------------
   // Register port
   // --------------------------------------------------------------------------
   task automatic write_register(reg_index_type idx, logic [PDATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'(int'(idx) * 4);
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_IMAGE_WIDTH:       cfg_shadow.image_width       = data[SIZE_W-1:0];
         REG_IMAGE_HEIGHT:      cfg_shadow.image_height      = data[SIZE_W-1:0];
         REG_CHANNEL_COUNT:     cfg_shadow.channel_count     = data[COUNT_W-1:0];
         REG_KERNEL_RADIUS:     cfg_shadow.kernel_radius     = data[RAD_W-1:0];
         REG_PRESERVE_CHANNELS: cfg_shadow.preserve_channels = data[0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // only ever called with the block drained
   task automatic apply_config(int width, int height, int count, int radius, int preserve);
      wait_idle();
      write_register(REG_IMAGE_WIDTH, PDATA_W'(width));
      write_register(REG_IMAGE_HEIGHT, PDATA_W'(height));
      write_register(REG_CHANNEL_COUNT, PDATA_W'(count));
      write_register(REG_KERNEL_RADIUS, PDATA_W'(radius));
      write_register(REG_PRESERVE_CHANNELS, PDATA_W'(preserve));
      settings_used++;
   endtask

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------
   // Whole 7x7 kernel first, so no compute ever meets an unwritten coefficient.
   task automatic test_kernel_store();
      sender_idles = 1'b0;
      for (int ky = 0; ky < MAX_KERNEL; ky++) begin
         for (int kx = 0; kx < MAX_KERNEL; kx++) begin
            send_word(REQ_LOAD_COEF, COORD_W'(kx), COORD_W'(ky), CHAN_W'(ky % 3), random_coef());
         end
      end
   endtask

   // Reset values: 256x256, three channels, 3x3 kernel, per-channel filtering.
   // Corners clamp, and a channel past the count clamps to the last one.
   task automatic test_reset_geometry();
      sender_idles = 1'b1;
      compute_at(8'd0, 8'd0, 2'd0);
      compute_at(8'd255, 8'd255, 2'd1);
      compute_at(8'd128, 8'd77, 2'd2);
      compute_at(8'd255, 8'd0, CHAN_BEYOND);
   endtask

   // 1x1 kernel on coefficient (0,0): positive and negative saturation, the
   // exact full-scale edge, and floor rounding of small negative sums.
   task automatic test_saturation_and_rounding();
      apply_config(256, 256, 3, 0, 1);
      send_word(REQ_LOAD_COEF, 8'd0, 8'd0, 2'd0, 16'sh7FFF);
      send_word(REQ_LOAD_PIXEL, 8'd10, 8'd10, 2'd0, 16'sh7FFF);
      send_word(REQ_COMPUTE, 8'd10, 8'd10, 2'd0, 16'sh0000);
      send_word(REQ_LOAD_PIXEL, 8'd11, 8'd10, 2'd0, -16'sh8000);
      send_word(REQ_COMPUTE, 8'd11, 8'd10, 2'd0, 16'shFFFF);
      send_word(REQ_LOAD_COEF, 8'd0, 8'd0, 2'd0, -16'sh8000);
      send_word(REQ_COMPUTE, 8'd11, 8'd10, 2'd0, 16'sh5555);
      send_word(REQ_LOAD_COEF, 8'd0, 8'd0, 2'd0, 16'sh0001);
      send_word(REQ_LOAD_PIXEL, 8'd12, 8'd10, 2'd0, -16'sh0001);
      send_word(REQ_COMPUTE, 8'd12, 8'd10, 2'd0, 16'shAAAA);
      send_word(REQ_LOAD_PIXEL, 8'd13, 8'd10, 2'd0, 16'sh3FFF);
      send_word(REQ_COMPUTE, 8'd13, 8'd10, 2'd0, 16'sh0000);
      // unity coefficient: full scale passes unsaturated
      send_word(REQ_LOAD_COEF, 8'd0, 8'd0, 2'd0, 16'sh4000);
      send_word(REQ_COMPUTE, 8'd10, 8'd10, 2'd0, 16'sh0000);
      send_word(REQ_COMPUTE, 8'd11, 8'd10, 2'd0, 16'sh0000);
   endtask

   // Registers at and past their limits; sizes and count saturate.
   task automatic test_register_extremes();
      apply_config(1, 1, 1, 3, 0);
      compute_at(8'd255, 8'd255, CHAN_BEYOND);
      apply_config(0, 0, 0, 3, 1);
      compute_at(8'd7, 8'd7, 2'd2);
      apply_config(511, 511, 3, 3, 0);
      compute_at(8'd255, 8'd255, 2'd0);
      compute_at(8'd0, 8'd0, 2'd1);
      apply_config(256, 256, 2, 2, 1);
      compute_at(8'd3, 8'd250, 2'd2);
   endtask

   // Small image: centre and neighbours past every edge.
   task automatic test_clamped_edges();
      apply_config(5, 4, 3, 3, 1);
      compute_at(8'd200, 8'd255, 2'd1);
      compute_at(8'd4, 8'd0, CHAN_BEYOND);
      compute_at(8'd0, 8'd3, 2'd0);
      apply_config(5, 4, 3, 2, 0);
      compute_at(8'd2, 8'd2, 2'd0);
   endtask

   // Dropped words must leave both stores alone; a stray coefficient write at
   // (7,0) would land on (0,1) of a 3x3 kernel.
   task automatic test_dropped_words();
      apply_config(256, 256, 3, 1, 1);
      compute_at(8'd40, 8'd40, 2'd2);
      send_word(REQ_UNUSED, 8'd40, 8'd40, 2'd2, 16'sh1234);
      send_word(REQ_LOAD_PIXEL, 8'd40, 8'd40, CHAN_BEYOND, 16'sh7FFF);
      send_word(REQ_LOAD_COEF, 8'd7, 8'd0, 2'd0, 16'sh7FFF);
      send_word(REQ_LOAD_COEF, 8'd0, 8'd200, 2'd0, -16'sh8000);
      compute_at(8'd40, 8'd40, 2'd2);
   endtask

   // Longest computes with the receiver held off: the block fills and must
   // stall its input until the hold ends.
   task automatic test_output_backpressure();
      apply_config(256, 256, 3, 3, 0);
      compute_at(8'd20, 8'd20, 2'd0);
      sender_idles     = 1'b0;
      hold_off_request = HOLD_OFF_CYCLES;
      for (int n = 0; n < 6; n++) begin
         compute_at(COORD_W'(20 + n % 2), 8'd20, CHAN_W'(n % 3));
      end
   endtask

   // Random settings; within each, mostly computes and loads with random
   // content, some dropped words mixed in, until the run's word budget is met.
   task automatic test_random_traffic();
      int w, h, nc, r, op, phase;
      phase = 0;
      while (words_counted < ITEM_TARGET) begin
         apply_config(random_extent(), random_extent(), $urandom_range(0, 3),
                      $urandom_range(0, 3), $urandom_range(0, 1));
         sender_idles = (phase % 4) != 3;  // every fourth setting runs flat out
         get_geometry(w, h, nc, r);
         for (int n = 0; n < PHASE_WORDS && words_counted < ITEM_TARGET; n++) begin
            op = $urandom_range(0, 99);
            if (op < 55) begin
               compute_at(pick_coord(w), pick_coord(h), CHAN_W'($urandom_range(0, 3)));
            end else if (op < 70) begin
               send_word(REQ_LOAD_PIXEL, pick_coord(w), pick_coord(h),
                         CHAN_W'($urandom_range(0, 2)), random_pixel());
            end else if (op < 80) begin
               send_word(REQ_LOAD_COEF, COORD_W'($urandom_range(0, MAX_KERNEL - 1)),
                         COORD_W'($urandom_range(0, MAX_KERNEL - 1)),
                         CHAN_W'($urandom), random_coef());
            end else begin
               send_noise();
            end
         end
         phase++;
      end
   endtask

   // --------------------------------------------------------------------------
   // Response side: stall pattern of its own plus the requested hold-off
   // --------------------------------------------------------------------------
   initial begin : result_sink
      int hold_left;
      int tick;
      int sink_mode;
      hold_left   = 0;
      tick        = 0;
      sink_mode   = 0;
      rsp_ch.ready = 1'b1;
      forever begin
         @(negedge clock);
         tick++;
         // cycle through: always ready, random stalls, fixed 4-of-7 pattern
         if (tick % 300 == 0) sink_mode = (sink_mode + 1) % 3;
         if (hold_off_request != 0) begin
            hold_left        = hold_off_request;
            hold_off_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (sink_mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= ($urandom_range(0, 2) != 0);
               default: rsp_ch.ready <= (tick % 7 < 4);
            endcase
         end
      end
   end

   // Each filtered pixel against the oldest expectation, field by field.
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_pixels.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("%t: result word with nothing expected: result %0d saturated %0b",
                        $realtime, rsp_ch.result, rsp_ch.saturated);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            results_checked++;
            if (rsp_ch.saturated) saturated_seen++;
            if (rsp_ch.result !== want.result || rsp_ch.saturated !== want.saturated) begin
               if (mismatches < MAX_REPORTS)
                  $display("%t: result word %0d: expected result %0d saturated %0b, got %0d %0b",
                           $realtime, results_checked, want.result, want.saturated,
                           rsp_ch.result, rsp_ch.saturated);
               mismatches++;
            end
         end
      end
   end

   // Ends the run if neither channel nor the register port moves for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
             || (psel && penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%t: no traffic for %0d cycles, %0d results outstanding",
               $realtime, WATCHDOG_LIMIT, expected_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Sequence
   // --------------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_LOAD_PIXEL;
      req_ch.col      = '0;
      req_ch.row      = '0;
      req_ch.chan     = '0;
      req_ch.value    = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      hold_off_request = 0;
      burst_left      = 0;
      sender_idles    = 1'b0;
      mismatches      = 0;
      words_counted   = 0;
      pixel_words     = 0;
      coef_words      = 0;
      compute_words   = 0;
      dropped_words   = 0;
      results_checked = 0;
      saturated_seen  = 0;
      settings_used   = 1;  // reset values count as the first
      cfg_shadow.image_width       = WIDTH_RESET;
      cfg_shadow.image_height      = HEIGHT_RESET;
      cfg_shadow.channel_count     = COUNT_RESET;
      cfg_shadow.kernel_radius     = RADIUS_RESET;
      cfg_shadow.preserve_channels = PRESERVE_RESET;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_kernel_store();
      test_reset_geometry();
      test_saturation_and_rounding();
      test_register_extremes();
      test_clamped_edges();
      test_dropped_words();
      test_output_backpressure();
      test_random_traffic();
      wait_idle();

      $display("Sent %0d pixel, %0d coefficient, %0d compute and %0d dropped words",
               pixel_words, coef_words, compute_words, dropped_words);
      $display("over %0d register settings; %0d results checked, %0d saturated, %0d mismatches",
               settings_used, results_checked, saturated_seen, mismatches);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
